// ===== design/ffhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffhp_pkg
// Shared types and codes for the FIFO free-list handle pool.
// ----------------------------------------------------------------------------
package ffhp_pkg;

  // Default handle space
  localparam int unsigned POOL_SIZE_DEFAULT = 256;

  // Payload widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_TRY   = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd3;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch request and launch memory reads
    logic commit;   // decide, update state and load the result register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy; // result register full and not taken this cycle
  } dp_stat_t;

endpackage

// ===== design/ffhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffhp_ctrl
// Request sequencer: accepts a request, then commits it once the result
// register can take the result.
// ----------------------------------------------------------------------------
module ffhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffhp_pkg::dp_stat_t dp_stat,
  output ffhp_pkg::dp_cmd_t  dp_cmd
);

  ffhp_pkg::state_t state;
  ffhp_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffhp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffhp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ffhp_pkg::S_EXEC;
        end
      end
      ffhp_pkg::S_EXEC: begin
        if (!dp_stat.out_busy) begin
          state_next = ffhp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffhp_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    unique case (state)
      ffhp_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
      end
      ffhp_pkg::S_EXEC: begin
        dp_cmd.commit = !dp_stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/ffhp_datapath.sv =====
// ----------------------------------------------------------------------------
// ffhp_datapath
// Allocation bitmap, released-handle FIFO, pool counters and the result
// register.
// ----------------------------------------------------------------------------
module ffhp_datapath #(
  parameter int unsigned POOL_SIZE = ffhp_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ffhp_pkg::dp_cmd_t                  dp_cmd,
  output ffhp_pkg::dp_stat_t                 dp_stat,
  input  logic [ffhp_pkg::OP_W-1:0]          op,
  input  logic [ffhp_pkg::HANDLE_W-1:0]      handle_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffhp_pkg::HANDLE_W-1:0]      handle_out,
  output logic [ffhp_pkg::STATUS_W-1:0]      status,
  output logic [ffhp_pkg::COUNT_W-1:0]       allocated_count,
  output logic [ffhp_pkg::COUNT_W-1:0]       released_count
);

  localparam int unsigned IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SIZE);

  // Storage: bitmap entries are only trusted below fresh_next
  logic                in_use_map [POOL_SIZE];
  logic [IDX_W-1:0]    released_fifo [POOL_SIZE];

  // Pool state
  logic [IDX_W-1:0]    fifo_head;
  logic [IDX_W-1:0]    fifo_tail;
  logic [CNT_W-1:0]    fifo_fill;
  logic [CNT_W-1:0]    fresh_next;
  logic [CNT_W-1:0]    in_use_total;

  // Captured request and registered memory reads
  logic [ffhp_pkg::OP_W-1:0]     op_q;
  logic [ffhp_pkg::HANDLE_W-1:0] hin_q;
  logic                          map_rd;
  logic [IDX_W-1:0]              fifo_rd;

  // Decision signals
  logic                          alloc_like;
  logic                          fifo_has;
  logic                          do_pop;
  logic                          do_fresh;
  logic                          do_grant;
  logic                          hin_in_range;
  logic [IDX_W-1:0]              hin_idx;
  logic                          hin_issued;
  logic                          do_free;
  logic [IDX_W-1:0]              grant_idx;
  logic [ffhp_pkg::STATUS_W-1:0] status_next;
  logic [CNT_W-1:0]              fifo_fill_next;
  logic [CNT_W-1:0]              in_use_total_next;

  // Capture request and read both memories
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      op_q    <= op;
      hin_q   <= handle_in;
      map_rd  <= in_use_map[IDX_W'(handle_in)];
      fifo_rd <= released_fifo[fifo_head];
    end
  end

  // Decide the outcome of the captured request
  always_comb begin
    alloc_like   = (op_q == ffhp_pkg::OP_ALLOC) || (op_q == ffhp_pkg::OP_TRY);
    fifo_has     = (fifo_fill != '0);
    do_pop       = alloc_like && fifo_has;
    do_fresh     = (op_q == ffhp_pkg::OP_ALLOC) && !fifo_has && (fresh_next != FULL_CNT);
    do_grant     = do_pop || do_fresh;
    hin_in_range = (32'(hin_q) < 32'(POOL_SIZE));
    hin_idx      = IDX_W'(hin_q);
    hin_issued   = (CNT_W'(hin_idx) < fresh_next);
    do_free      = (op_q == ffhp_pkg::OP_FREE) && hin_in_range && hin_issued && map_rd
                   && (fifo_fill != FULL_CNT);
    grant_idx    = do_pop ? fifo_rd : (do_fresh ? IDX_W'(fresh_next) : '0);

    status_next = ffhp_pkg::STAT_OK;
    case (op_q)
      ffhp_pkg::OP_ALLOC: begin
        if (!do_grant) begin
          status_next = ffhp_pkg::STAT_EXHAUSTED;
        end
      end
      ffhp_pkg::OP_TRY: begin
        if (!do_pop) begin
          status_next = ffhp_pkg::STAT_NONE;
        end
      end
      ffhp_pkg::OP_FREE: begin
        if (!do_free) begin
          status_next = ffhp_pkg::STAT_INVALID;
        end
      end
      default: begin
        status_next = ffhp_pkg::STAT_OK;
      end
    endcase

    fifo_fill_next = fifo_fill;
    if (do_pop) begin
      fifo_fill_next = fifo_fill - CNT_W'(1);
    end else if (do_free) begin
      fifo_fill_next = fifo_fill + CNT_W'(1);
    end

    in_use_total_next = in_use_total;
    if (do_grant) begin
      in_use_total_next = in_use_total + CNT_W'(1);
    end else if (do_free) begin
      in_use_total_next = in_use_total - CNT_W'(1);
    end
  end

  // Update the bitmap on grant or release
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && do_grant) begin
      in_use_map[grant_idx] <= 1'b1;
    end else if (dp_cmd.commit && do_free) begin
      in_use_map[hin_idx] <= 1'b0;
    end
  end

  // Append released handle to the FIFO
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && do_free) begin
      released_fifo[fifo_tail] <= hin_idx;
    end
  end

  // Advance pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head    <= '0;
      fifo_tail    <= '0;
      fifo_fill    <= '0;
      fresh_next   <= '0;
      in_use_total <= '0;
    end else if (dp_cmd.commit) begin
      fifo_fill    <= fifo_fill_next;
      in_use_total <= in_use_total_next;
      if (do_pop) begin
        fifo_head <= (fifo_head == LAST_IDX) ? '0 : fifo_head + IDX_W'(1);
      end
      if (do_free) begin
        fifo_tail <= (fifo_tail == LAST_IDX) ? '0 : fifo_tail + IDX_W'(1);
      end
      if (do_fresh) begin
        fresh_next <= fresh_next + CNT_W'(1);
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      handle_out      <= ffhp_pkg::HANDLE_W'(grant_idx);
      status          <= status_next;
      allocated_count <= ffhp_pkg::COUNT_W'(in_use_total_next);
      released_count  <= ffhp_pkg::COUNT_W'(fifo_fill_next);
    end
  end

  assign dp_stat.out_busy = out_valid && !out_ready;

endmodule

// ===== design/fifo_free_list_handle_pool.sv =====
// ----------------------------------------------------------------------------
// fifo_free_list_handle_pool
// Handle pool with FIFO reuse of released handles.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): op and handle_in. op selects
//   allocate, try allocate (released handles only) or deallocate.
//   Result channel (out_valid/out_ready): handle_out, status and the
//   allocated and released counts after the request.
//   Each request is captured, with registered reads of the bitmap and
//   released FIFO, in the idle state and committed in the execute state.
//   A new request is not taken until the previous one has committed.
//   The result is loaded into the output register when the request commits.
//   A waiting result sits in an output register while the next request
//   is accepted and read; that request commits once the result is taken,
//   so a stalled receiver holds the pool state and back-pressures requests.
//   Reset clears the FIFO pointers, the counts and the fresh-handle
//   counter; the bitmap needs no clearing since entries at or above the
//   fresh-handle counter are treated as free. The controller leaves
//   reset in its idle state, ready to accept a request.
// ----------------------------------------------------------------------------
module fifo_free_list_handle_pool #(
  parameter int unsigned POOL_SIZE = ffhp_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffhp_pkg::OP_W-1:0]     op,
  input  logic [ffhp_pkg::HANDLE_W-1:0] handle_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffhp_pkg::HANDLE_W-1:0] handle_out,
  output logic [ffhp_pkg::STATUS_W-1:0] status,
  output logic [ffhp_pkg::COUNT_W-1:0]  allocated_count,
  output logic [ffhp_pkg::COUNT_W-1:0]  released_count
);

  ffhp_pkg::dp_cmd_t  dp_cmd;
  ffhp_pkg::dp_stat_t dp_stat;

  // Sequencer
  ffhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  // Pool storage and result register
  ffhp_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .op              (op),
    .handle_in       (handle_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .handle_out      (handle_out),
    .status          (status),
    .allocated_count (allocated_count),
    .released_count  (released_count)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, try-allocate, deallocate and unused requests into the
// handle pool and checks every result against a behavioral pool model that
// tracks the in-use bitmap, the released FIFO and the fresh-handle counter.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned POOL_SIZE = ffhp_pkg::POOL_SIZE_DEFAULT;
  localparam logic [ffhp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN = 80;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [ffhp_pkg::HANDLE_W-1:0] handle;
    logic [ffhp_pkg::STATUS_W-1:0] status;
    logic [ffhp_pkg::COUNT_W-1:0]  alloc_cnt;
    logic [ffhp_pkg::COUNT_W-1:0]  rel_cnt;
  } pool_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ffhp_pkg::OP_W-1:0]     op = '0;
  logic [ffhp_pkg::HANDLE_W-1:0] handle_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ffhp_pkg::HANDLE_W-1:0] handle_out;
  logic [ffhp_pkg::STATUS_W-1:0] status;
  logic [ffhp_pkg::COUNT_W-1:0]  allocated_count;
  logic [ffhp_pkg::COUNT_W-1:0]  released_count;

  // Pool model state
  bit                            pool_in_use [POOL_SIZE];
  logic [ffhp_pkg::HANDLE_W-1:0] pool_released [$];
  int                            pool_fresh;
  int                            pool_alloc_total;

  pool_result_t        pending_results [$];
  int                  error_count;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  hold_seq;
  int                  hold_seen;
  int                  hold_left;

  fifo_free_list_handle_pool #(
    .POOL_SIZE(POOL_SIZE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .handle_in(handle_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .handle_out(handle_out),
    .status(status),
    .allocated_count(allocated_count),
    .released_count(released_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the pool model by one request and return the result it yields
  function automatic pool_result_t pool_predict(
      logic [ffhp_pkg::OP_W-1:0] req_op,
      logic [ffhp_pkg::HANDLE_W-1:0] req_handle);
    pool_result_t r;
    r.handle = '0;
    r.status = ffhp_pkg::STAT_OK;
    if (req_op == ffhp_pkg::OP_ALLOC || req_op == ffhp_pkg::OP_TRY) begin
      if (pool_released.size() != 0) begin
        r.handle = pool_released[0];
        pool_released.delete(0);
        pool_in_use[r.handle] = 1'b1;
        pool_alloc_total++;
      end else if (req_op == ffhp_pkg::OP_TRY) begin
        r.status = ffhp_pkg::STAT_NONE;
      end else if (pool_fresh < POOL_SIZE) begin
        r.handle = ffhp_pkg::HANDLE_W'(pool_fresh);
        pool_fresh++;
        pool_in_use[r.handle] = 1'b1;
        pool_alloc_total++;
      end else begin
        r.status = ffhp_pkg::STAT_EXHAUSTED;
      end
    end else if (req_op == ffhp_pkg::OP_FREE) begin
      if (pool_in_use[req_handle]) begin
        pool_in_use[req_handle] = 1'b0;
        pool_alloc_total--;
        pool_released.insert(pool_released.size(), req_handle);
      end else begin
        r.status = ffhp_pkg::STAT_INVALID;
      end
    end
    r.alloc_cnt = ffhp_pkg::COUNT_W'(pool_alloc_total);
    r.rel_cnt   = ffhp_pkg::COUNT_W'(pool_released.size());
    return r;
  endfunction

  // Pick a random handle that is currently allocated, or -1 if none is
  function automatic int pick_in_use();
    int start;
    int idx;
    start = $urandom_range(POOL_SIZE - 1);
    for (int k = 0; k < POOL_SIZE; k++) begin
      idx = (start + k) % POOL_SIZE;
      if (pool_in_use[idx]) return idx;
    end
    return -1;
  endfunction

  // Offer one request, hold it until accepted, then record its result
  task automatic send_request(logic [ffhp_pkg::OP_W-1:0] req_op,
                              logic [ffhp_pkg::HANDLE_W-1:0] req_handle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= req_op;
    handle_in <= req_handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), pool_predict(req_op, req_handle));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Take results, compare them and drive the receiver's ready
  always @(posedge clk) begin : result_check
    pool_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: handle_out %0d status %0d", handle_out, status);
        error_count++;
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (handle_out !== exp_r.handle) begin
          $error("handle_out: expected %0d, got %0d", exp_r.handle, handle_out);
          error_count++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          error_count++;
        end
        if (allocated_count !== exp_r.alloc_cnt) begin
          $error("allocated_count: expected %0d, got %0d", exp_r.alloc_cnt,
                 allocated_count);
          error_count++;
        end
        if (released_count !== exp_r.rel_cnt) begin
          $error("released_count: expected %0d, got %0d", exp_r.rel_cnt, released_count);
          error_count++;
        end
      end
    end
    // Hold off for a long stretch on request, else stall at random
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // End the run when nothing is accepted for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Walk the special cases by hand
  task automatic test_directed();
    tx_idle_pct = 36;
    rx_idle_pct = 84;
    send_request(ffhp_pkg::OP_TRY, 8'd0);      // try on empty FIFO
    send_request(ffhp_pkg::OP_FREE, 8'd0);     // free of a never-issued handle
    send_request(OP_UNUSED, 8'd255);           // unused op is ignored
    send_request(ffhp_pkg::OP_ALLOC, 8'd255);  // fresh 0
    send_request(ffhp_pkg::OP_ALLOC, 8'd0);    // fresh 1
    send_request(ffhp_pkg::OP_ALLOC, 8'd128);  // fresh 2
    send_request(ffhp_pkg::OP_FREE, 8'd1);
    send_request(ffhp_pkg::OP_FREE, 8'd1);     // already released
    send_request(ffhp_pkg::OP_FREE, 8'd255);   // never issued
    send_request(ffhp_pkg::OP_FREE, 8'd0);
    send_request(ffhp_pkg::OP_TRY, 8'd0);      // oldest released first
    send_request(ffhp_pkg::OP_ALLOC, 8'd0);    // next from FIFO
    send_request(ffhp_pkg::OP_ALLOC, 8'd0);    // fresh again once FIFO is empty
    send_request(ffhp_pkg::OP_FREE, 8'd2);
    send_request(ffhp_pkg::OP_FREE, 8'd3);
    send_request(OP_UNUSED, 8'd0);
    send_request(ffhp_pkg::OP_TRY, 8'd170);
    send_request(ffhp_pkg::OP_ALLOC, 8'd85);
    send_request(ffhp_pkg::OP_TRY, 8'd0);      // FIFO empty again
    send_request(ffhp_pkg::OP_FREE, 8'd4);     // at the fresh counter, never issued
    drain_results();
  endtask

  // Mostly well-formed traffic: most frees target allocated handles
  task automatic test_random(int count, int tx_pct, int rx_pct);
    int pick;
    int roll;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        send_request(ffhp_pkg::OP_ALLOC, ffhp_pkg::HANDLE_W'($urandom));
      end else if (roll < 50) begin
        send_request(ffhp_pkg::OP_TRY, ffhp_pkg::HANDLE_W'($urandom));
      end else if (roll < 85) begin
        pick = pick_in_use();
        if (pick < 0) send_request(ffhp_pkg::OP_FREE, ffhp_pkg::HANDLE_W'($urandom));
        else send_request(ffhp_pkg::OP_FREE, ffhp_pkg::HANDLE_W'(pick));
      end else if (roll < 95) begin
        send_request(ffhp_pkg::OP_FREE, ffhp_pkg::HANDLE_W'($urandom));
      end else begin
        send_request(OP_UNUSED, ffhp_pkg::HANDLE_W'($urandom));
      end
    end
    drain_results();
  endtask

  // Stall the receiver long enough that the pool stops taking requests
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq++;
    for (int n = 0; n < 12; n++) begin
      if (n % 3 == 2) send_request(ffhp_pkg::OP_FREE, ffhp_pkg::HANDLE_W'(n));
      else send_request(ffhp_pkg::OP_ALLOC, ffhp_pkg::HANDLE_W'($urandom));
    end
    drain_results();
  endtask

  // Use up the handle space, release every handle, then reuse in FIFO order
  task automatic test_exhaust();
    logic [ffhp_pkg::HANDLE_W-1:0] owned [$];
    logic [ffhp_pkg::HANDLE_W-1:0] tmp;
    int j;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (pool_fresh < POOL_SIZE || pool_released.size() != 0) begin
      send_request(ffhp_pkg::OP_ALLOC, ffhp_pkg::HANDLE_W'($urandom));
    end
    send_request(ffhp_pkg::OP_ALLOC, 8'd0);
    send_request(ffhp_pkg::OP_ALLOC, 8'd255);
    send_request(ffhp_pkg::OP_TRY, 8'd0);
    // Release in shuffled order so reuse order is not trivial
    for (int h = 0; h < POOL_SIZE; h++) begin
      if (pool_in_use[h]) owned.insert(owned.size(), ffhp_pkg::HANDLE_W'(h));
    end
    for (int k = owned.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = owned[k];
      owned[k] = owned[j];
      owned[j] = tmp;
    end
    foreach (owned[k]) send_request(ffhp_pkg::OP_FREE, owned[k]);
    send_request(ffhp_pkg::OP_FREE, owned[0]);
    send_request(ffhp_pkg::OP_FREE, 8'd255);
    send_request(OP_UNUSED, 8'd170);
    for (int n = 0; n < 40; n++) begin
      if (n % 2 == 0) send_request(ffhp_pkg::OP_TRY, ffhp_pkg::HANDLE_W'($urandom));
      else send_request(ffhp_pkg::OP_ALLOC, ffhp_pkg::HANDLE_W'($urandom));
    end
    drain_results();
  endtask

  initial begin
    error_count = 0;
    pool_fresh = 0;
    pool_alloc_total = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(100, 36, 84);
    test_random(100, 84, 36);
    test_backpressure();
    test_random(100, 0, 0);
    test_exhaust();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
